>>> rtl/sssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared types and constants for the shortest-path engine.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int unsigned MaxVerticesDefault = 64;
  localparam int unsigned MaxEdgesDefault    = 1024;

  localparam int unsigned VertexW = 6;
  localparam int unsigned WeightW = 16;
  localparam int unsigned DistW   = 23;
  localparam int unsigned CountW  = 7;

  localparam logic [DistW-1:0] DistInf = 23'h7FFFFF;
  localparam logic [DistW-1:0] DistMax = 23'h3FFFFF;

  localparam logic OpAddEdge = 1'b0;
  localparam logic OpRun     = 1'b1;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_PICK,
    ST_RELAX,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/single_source_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path
// Dijkstra shortest-path engine with an edge store and a minimum-scan unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one input beat: op 0 appends an edge to the edge store,
//   op 1 starts a search from from_vertex. s_axis_tready is low
//   for the whole search and while its results drain.
//   m_axis delivers one beat per vertex in index order, tlast on the last.
//   A run makes a clearing pass over all MAX_VERTICES table entries, then
//   for each settled vertex a minimum scan, one pick step and a walk of the
//   edge store (one edge per cycle through a read, add and compare pipeline),
//   then a final scan and pick that find nothing, then N result beats, N
//   the vertex count. A stalled receiver simply holds the current result
//   beat; the engine waits until it is taken.
//   Reset empties the edge store, clears the overflow flag and sets the
//   vertex count to 64. cfg_we writes the vertex count; the user must
//   assert it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module single_source_shortest_path #(
  parameter int unsigned MAX_VERTICES = sssp_pkg::MaxVerticesDefault,
  parameter int unsigned MAX_EDGES    = sssp_pkg::MaxEdgesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // from_vertex[5:0], to_vertex[11:6], edge_weight[27:12], zero fill
  input  logic [31:0] s_axis_tdata,
  // op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vertex_index[5:0], distance[27:6], reachable[28], zero fill
  output logic [31:0] m_axis_tdata,
  // edge_overflow
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import sssp_pkg::*;

  localparam int unsigned EdgeAw = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned TotalW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EdgeW  = 2 * VertexW + WeightW;

  state_t state, state_next;

  logic [CountW-1:0]  vertex_count;
  logic [CountW-1:0]  n_act;
  logic [TotalW-1:0]  edge_total;
  logic               overflow_flag;

  logic [EdgeW-1:0]   edge_mem [MAX_EDGES];
  logic [EdgeW-1:0]   edge_rd;
  logic [DistW-1:0]   dist_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] settled;

  logic [CountW-1:0]  idx;
  logic [TotalW-1:0]  eidx;
  logic               rd_valid;
  logic [VertexW-1:0] best;
  logic [DistW-1:0]   bestd;
  logic               best_found;
  logic [VertexW-1:0] start;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Clamp the vertex count into the supported range.
  always_comb begin
    if (vertex_count == '0) n_act = CountW'(1);
    else if (vertex_count > CountW'(MAX_VERTICES)) n_act = CountW'(MAX_VERTICES);
    else n_act = vertex_count;
  end

  // Edge store: written on add beats, read one entry per cycle in relax.
  always_ff @(posedge clk) begin
    if (in_fire && s_axis_tuser == OpAddEdge && edge_total < TotalW'(MAX_EDGES))
      edge_mem[edge_total[EdgeAw-1:0]] <= s_axis_tdata[EdgeW-1:0];
    edge_rd <= edge_mem[eidx[EdgeAw-1:0]];
  end

  // Distance table port: registered read data, one write per cycle.
  logic               d_we;
  logic [VertexW-1:0] d_waddr;
  logic [DistW-1:0]   d_wdata;
  logic [VertexW-1:0] d_raddr;
  logic [DistW-1:0]   d_rd;

  // Relax datapath: one saturating add per cycle, then a compare
  // against the registered table entry of the edge head.
  logic [VertexW-1:0] r_tail, r_head;
  logic [WeightW-1:0] r_w;
  logic [DistW:0]     r_sum;
  logic [DistW-1:0]   r_nd;
  logic               r_upd;
  logic               b_valid;
  logic [VertexW-1:0] b_head;
  logic [DistW-1:0]   b_nd;
  assign r_tail = edge_rd[VertexW-1:0];
  assign r_head = edge_rd[2*VertexW-1:VertexW];
  assign r_w    = edge_rd[EdgeW-1:2*VertexW];
  assign r_sum  = {1'b0, bestd} + (DistW+1)'(r_w);
  assign r_nd   = (r_sum > (DistW+1)'(DistMax)) ? DistMax : r_sum[DistW-1:0];
  assign r_upd  = b_valid && b_nd < d_rd;

  // Scan compare against the current candidate, in the cycle after the read.
  logic [VertexW-1:0] sv;
  logic               scan_vld;
  logic [VertexW-1:0] scan_idx;
  logic               s_better;
  assign sv = idx[VertexW-1:0];
  assign s_better = scan_vld && !settled[scan_idx] && d_rd < bestd;

  // Table write source: clearing pass or a relax update.
  always_comb begin
    d_we    = 1'b0;
    d_waddr = idx[VertexW-1:0];
    d_wdata = DistInf;
    if (state == ST_CLEAR) begin
      d_we    = 1'b1;
      d_wdata = (idx[VertexW-1:0] == start && CountW'(start) < n_act) ? '0 : DistInf;
    end else if (state == ST_RELAX && r_upd) begin
      d_we    = 1'b1;
      d_waddr = b_head;
      d_wdata = b_nd;
    end
  end

  // Table read address: scan index, edge head, or the result entry to show.
  always_comb begin
    case (state)
      ST_SCAN:  d_raddr = sv;
      ST_RELAX: d_raddr = r_head;
      ST_EMIT:  d_raddr = m_axis_tready ? idx[VertexW-1:0] + VertexW'(1)
                                        : idx[VertexW-1:0];
      default:  d_raddr = idx[VertexW-1:0];
    endcase
  end

  // A write to the entry being read is passed straight to the read data.
  always_ff @(posedge clk) begin
    if (d_we) dist_mem[d_waddr] <= d_wdata;
    d_rd <= (d_we && d_waddr == d_raddr) ? d_wdata : dist_mem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire && s_axis_tuser == OpRun) state_next = ST_CLEAR;
      ST_CLEAR: if (idx == CountW'(MAX_VERTICES - 1)) state_next = ST_SCAN;
      ST_SCAN:  if (idx == n_act) state_next = ST_PICK;
      ST_PICK:  state_next = best_found ? ST_RELAX : ST_EMIT;
      ST_RELAX: if (eidx == edge_total && !rd_valid) state_next = ST_SCAN;
      ST_EMIT:  if (m_axis_tready && idx == n_act - CountW'(1)) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= CountW'(64);
      edge_total    <= '0;
      overflow_flag <= 1'b0;
      idx <= '0;
      eidx <= '0;
      rd_valid <= 1'b0;
      settled <= '0;
      best_found <= 1'b0;
      b_valid <= 1'b0;
      scan_vld <= 1'b0;
    end else begin
      if (cfg_we) vertex_count <= cfg_wdata;
      if (in_fire && s_axis_tuser == OpAddEdge) begin
        if (edge_total < TotalW'(MAX_EDGES)) edge_total <= edge_total + TotalW'(1);
        else overflow_flag <= 1'b1;
      end
      b_valid  <= state == ST_RELAX && rd_valid && r_tail == best
                  && CountW'(r_head) < n_act;
      b_head   <= r_head;
      b_nd     <= r_nd;
      scan_vld <= state == ST_SCAN && idx < n_act;
      scan_idx <= sv;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          start <= s_axis_tdata[VertexW-1:0];
        end
        ST_CLEAR: begin
          settled <= '0;
          bestd <= DistInf;
          best_found <= 1'b0;
          idx <= (idx == CountW'(MAX_VERTICES - 1)) ? '0 : idx + CountW'(1);
        end
        ST_SCAN: begin
          if (s_better) begin
            bestd <= d_rd;
            best <= scan_idx;
            best_found <= 1'b1;
          end
          idx <= (idx == n_act) ? '0 : idx + CountW'(1);
          eidx <= '0;
          rd_valid <= 1'b0;
        end
        ST_PICK: begin
          if (best_found) settled[best] <= 1'b1;
        end
        ST_RELAX: begin
          rd_valid <= eidx < edge_total;
          if (eidx < edge_total) eidx <= eidx + TotalW'(1);
          if (state_next == ST_SCAN) begin
            bestd <= DistInf;
            best_found <= 1'b0;
            rd_valid <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) idx <= idx + CountW'(1);
        end
        default: ;
      endcase
    end
  end

  // Result beat built from the distance table.
  logic [DistW-1:0] e_d;
  logic             e_reach;
  assign e_d     = d_rd;
  assign e_reach = e_d != DistInf;

  assign s_axis_tready = state == ST_IDLE;
  assign m_axis_tvalid = state == ST_EMIT;
  assign m_axis_tdata  = {3'b000, e_reach, e_reach ? e_d[DistW-2:0] : 22'd0,
                          idx[VertexW-1:0]};
  assign m_axis_tuser  = overflow_flag;
  assign m_axis_tlast  = idx == n_act - CountW'(1);

`ifndef NO_ASSERTIONS
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("output while accepting");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    edge_total <= TotalW'(MAX_EDGES)) else $error("edge count overrun");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |=> overflow_flag) else $error("overflow flag cleared");
  a_pick_settles: assert property (@(posedge clk) disable iff (rst)
    state == ST_PICK && best_found |=> settled[$past(best)])
    else $error("picked vertex not settled");
`endif

endmodule
